// File: hw/rtl/tli_pkg.sv
// Shared types and constants for the text line index block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tli_pkg;

  localparam int unsigned MAX_LINES      = 4096;
  localparam int unsigned MAX_TEXT_BYTES = 1048576;

  localparam int unsigned IDX_W  = $clog2(MAX_LINES);  // line table address
  localparam int unsigned LINE_W = IDX_W + 1;          // line count, holds MAX_LINES
  localparam int unsigned OFF_W  = 21;                 // byte offsets and columns
  localparam int unsigned BYTE_W = 8;

  // tdata widths: input text_byte + query_offset, output line + column + overflow
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [OFF_W-1:0]  offset_t;

  // Controller to datapath
  typedef struct packed {
    logic accept_byte;   // take a text beat
    logic accept_query;  // take a query beat and set up the search
    logic write2;        // record the deferred second line start
    logic step;          // one binary search step
    logic load_out;      // move the result into the output register
  } tli_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic two_starts;    // this text beat opens two lines
    logic need_search;   // this query needs the table search
    logic search_done;   // search interval has narrowed to one line
    logic out_free;      // output register can take a result
  } tli_sts_t;

endpackage

// File: hw/rtl/text_line_index.sv
// Text line index: a text streams in one byte per beat and the block records
// the offset at which each line begins (CR, LF or the pair CR LF ends a line;
// the pair counts as one break). After the beat marked tlast, query beats map
// a byte offset to a 1-based line and column; an offset equal to the text
// length maps to the last line, and offsets past the end or queries made
// before the text is complete return found = 0 with zero line and column.
// Up to 4096 line starts are held in a single-port-read RAM; further starts
// are dropped and the sticky overflow bit is raised on every later result.
// A text beat holds the input while a second line start is written when a
// CR is followed by a final CR (two line starts share the one table write
// port). A query goes through set-up, one table read per binary search
// step, a final compare of the last read and the result load, which waits
// for a free output register; a query at the text end or outside the text
// skips the search. tready stays low while a query is worked on; the result
// then waits in the output register while text beats keep flowing in.
// The table needs no clearing after reset: only entries already written are
// ever probed, and entry 0 is held as a constant.
// Depends on tli_pkg, tli_ctrl, tli_dpath and tli_ram.
`timescale 1ns / 1ps

module text_line_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // query / text input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tli_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte, [28:8] query_offset
  input  logic                             s_axis_tuser,   // [0] mode (0 text, 1 query)
  input  logic                             s_axis_tlast,   // last_byte
  // result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tli_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [12:0] line_number, [33:13] column,
                                                           // [34] table_overflow
  output logic                             m_axis_tuser    // [0] found
);
  import tli_pkg::*;

  tli_cmd_t cmd;
  tli_sts_t sts;

  // Sequence beats: text beats, the deferred second line start, and queries through search.
  tli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .mode_i     (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the line table, counters, search interval and result register.
  tli_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .text_byte_i    (s_axis_tdata[BYTE_W-1:0]),
    .last_byte_i    (s_axis_tlast),
    .query_offset_i (s_axis_tdata[BYTE_W+OFF_W-1:BYTE_W]),
    .m_tvalid_o     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_o      (m_axis_tdata),
    .m_tuser_o      (m_axis_tuser)
  );

endmodule

// File: hw/rtl/tli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module tli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tli_ctrl.sv
// Sequencing state machine for the text line index block.
// Depends on tli_pkg for the command and status structs.
`timescale 1ns / 1ps

module tli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              mode_i,
  output logic              s_tready_o,
  input  tli_pkg::tli_sts_t sts_i,
  output tli_pkg::tli_cmd_t cmd_o
);
  import tli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WRITE2 = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_d, state_q;
  logic   fire;

  assign s_tready_o = (state_q == S_IDLE);
  assign fire       = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (fire && !mode_i) begin
          cmd_o.accept_byte = 1'b1;
          if (sts_i.two_starts) begin
            state_d = S_WRITE2;
          end
        end else if (fire) begin
          cmd_o.accept_query = 1'b1;
          state_d = sts_i.need_search ? S_SEARCH : S_FINISH;
        end
      end
      S_WRITE2: begin
        cmd_o.write2 = 1'b1;
        state_d      = S_IDLE;
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.search_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A searching query hands over to the result load state once its search is done.
  a_search_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && sts_i.search_done) |=> (state_q == S_FINISH))
    else $error("search did not hand over to result load");

  // A double line start is followed by its second write.
  a_write2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept_byte && sts_i.two_starts) |=> cmd_o.write2)
    else $error("second line start not written");

endmodule

// File: hw/rtl/tli_dpath.sv
// Datapath of the text line index block: line start table, text counters,
// binary search registers and the output register. Depends on tli_pkg, tli_ram.
`timescale 1ns / 1ps

module tli_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tli_pkg::tli_cmd_t                cmd_i,
  output tli_pkg::tli_sts_t                sts_o,
  input  logic [tli_pkg::BYTE_W-1:0]       text_byte_i,
  input  logic                             last_byte_i,
  input  tli_pkg::offset_t                 query_offset_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [tli_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic                             m_tuser_o
);
  import tli_pkg::*;

  // Text state
  offset_t   byte_cnt_q, byte_cnt_d;
  line_t     line_cnt_q;
  offset_t   last_start_q;
  logic      cr_q, cr_d;
  logic      complete_q;
  logic      overflow_q;
  offset_t   pend_at_q;

  // Search state
  offset_t   pos_q;
  line_t     lo_q, hi_q, mid_q;
  offset_t   lo_start_q;
  logic      hit_q;
  logic      rd_pend_q;

  // Output register
  logic                  out_valid_q;
  logic [LINE_W-1:0]     out_line_q;
  logic [OFF_W-1:0]      out_col_q;
  logic                  out_found_q;
  logic                  out_ovf_q;

  // ---------------- text beat decode ----------------
  logic    in_range, is_cr, is_lf;
  logic    add_a, add_b;
  offset_t at_a, pos_inc;
  logic    cr_t;

  assign in_range = (byte_cnt_q != OFF_W'(MAX_TEXT_BYTES));
  assign is_cr    = (text_byte_i == CH_CR);
  assign is_lf    = (text_byte_i == CH_LF);
  assign pos_inc  = byte_cnt_q + OFF_W'(1);

  always_comb begin
    add_a      = 1'b0;
    at_a       = pos_inc;
    cr_t       = cr_q;
    byte_cnt_d = byte_cnt_q;
    if (in_range) begin
      byte_cnt_d = pos_inc;
      if (cr_q) begin
        add_a = 1'b1;
        if (is_lf) begin
          cr_t = 1'b0;
        end else begin
          at_a = byte_cnt_q;
          cr_t = is_cr;
        end
      end else begin
        cr_t  = is_cr;
        add_a = is_lf;
      end
    end
    // a pending CR at the last byte ends its line at once
    add_b = last_byte_i && cr_t;
    cr_d  = last_byte_i ? 1'b0 : cr_t;
  end

  // ---------------- line start recording ----------------
  logic    add_en, tbl_full;
  offset_t add_at;

  assign tbl_full = (line_cnt_q == LINE_W'(MAX_LINES));

  always_comb begin
    add_en = 1'b0;
    add_at = pend_at_q;
    if (cmd_i.accept_byte && !complete_q) begin
      add_en = add_a || add_b;
      add_at = add_a ? at_a : byte_cnt_d;
    end else if (cmd_i.write2) begin
      add_en = 1'b1;
    end
  end

  // ---------------- search step ----------------
  offset_t rd_data, lo_start_n;
  line_t   lo_n, hi_n, span, mid_n;
  logic    done_n, rd_en;

  always_comb begin
    lo_n       = lo_q;
    hi_n       = hi_q;
    lo_start_n = lo_start_q;
    if (rd_pend_q) begin
      if (rd_data <= pos_q) begin
        lo_n       = mid_q;
        lo_start_n = rd_data;
      end else begin
        hi_n = mid_q;
      end
    end
  end

  assign span   = hi_n - lo_n;
  assign done_n = (span <= LINE_W'(1));
  assign mid_n  = lo_n + (span >> 1);
  assign rd_en  = cmd_i.step && !done_n;

  tli_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MAX_LINES)
  ) u_starts (
    .clk_i   (clk_i),
    .we_i    (add_en && !tbl_full),
    .waddr_i (line_cnt_q[IDX_W-1:0]),
    .wdata_i (add_at),
    .re_i    (rd_en),
    .raddr_i (mid_n[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------- query set-up ----------------
  logic q_hit, q_at_end;

  assign q_hit    = complete_q && (query_offset_i <= byte_cnt_q);
  assign q_at_end = (query_offset_i == byte_cnt_q);

  // ---------------- status ----------------
  always_comb begin
    sts_o             = '0;
    sts_o.two_starts  = !complete_q && add_a && add_b;
    sts_o.need_search = q_hit && !q_at_end;
    sts_o.search_done = done_n;
    sts_o.out_free    = !out_valid_q || m_tready_i;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      line_cnt_q   <= LINE_W'(1);
      last_start_q <= '0;
      cr_q         <= 1'b0;
      complete_q   <= 1'b0;
      overflow_q   <= 1'b0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept_byte && !complete_q) begin
        byte_cnt_q <= byte_cnt_d;
        cr_q       <= cr_d;
        complete_q <= last_byte_i;
      end
      if (add_en) begin
        if (tbl_full) begin
          overflow_q <= 1'b1;
        end else begin
          line_cnt_q   <= line_cnt_q + LINE_W'(1);
          last_start_q <= add_at;
        end
      end
      if (cmd_i.accept_query) begin
        rd_pend_q <= 1'b0;
      end else if (cmd_i.step) begin
        rd_pend_q <= !done_n;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_byte) begin
      pend_at_q <= byte_cnt_d;
    end
    if (cmd_i.accept_query) begin
      pos_q      <= query_offset_i;
      hit_q      <= q_hit;
      hi_q       <= line_cnt_q;
      mid_q      <= '0;
      lo_q       <= q_at_end ? (line_cnt_q - LINE_W'(1)) : '0;
      lo_start_q <= q_at_end ? last_start_q : '0;
    end else if (cmd_i.step) begin
      lo_q       <= lo_n;
      hi_q       <= hi_n;
      lo_start_q <= lo_start_n;
      mid_q      <= mid_n;
    end
    if (cmd_i.load_out) begin
      out_line_q  <= hit_q ? (lo_q + LINE_W'(1)) : '0;
      out_col_q   <= hit_q ? (pos_q - lo_start_q + OFF_W'(1)) : '0;
      out_found_q <= hit_q;
      out_ovf_q   <= overflow_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_found_q;
  assign m_tdata_o  = {{(OUT_DATA_W - LINE_W - OFF_W - 1){1'b0}},
                       out_ovf_q, out_col_q, out_line_q};

  // Line count stays between one and the table depth.
  a_line_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_cnt_q != '0) && (line_cnt_q <= LINE_W'(MAX_LINES)))
    else $error("line count out of range");

  // An outstanding read always lies strictly inside the search interval.
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (mid_q > lo_q) && (mid_q < hi_q))
    else $error("search probe outside interval");

  // Overflow is sticky until reset.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow flag cleared");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_tready_i))
    else $error("pending result overwritten");

endmodule
